// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants for the modular exponentiation block
// Field widths, reduction step counts and the request/response bundles used
// between the sequencer and the shared multiply-reduce unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int EXP_BITS  = 31;
  localparam int MOD_BITS  = 16;
  localparam int PROD_W    = 2 * MOD_BITS;
  localparam int RED_STEPS = PROD_W / 2;
  localparam int STEP_W    = $clog2(RED_STEPS + 1);
  localparam int IDX_W     = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  typedef logic [MOD_BITS-1:0] mod_word_t;
  typedef logic [EXP_BITS-1:0] exp_word_t;
  typedef logic [IDX_W-1:0]    bit_idx_t;

  // One multiply-reduce job: op_a * op_b mod modulus
  typedef struct packed {
    logic      start;
    mod_word_t op_a;
    mod_word_t op_b;
    mod_word_t modulus;
  } mexp_req_t;

  typedef struct packed {
    logic      done;
    mod_word_t result;
  } mexp_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_REDUCE = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_SQUARE = 6'b001000,
    ST_MULT   = 6'b010000,
    ST_FINISH = 6'b100000
  } mexp_state_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation: base ^ exponent mod modulus
// Left-to-right square-and-multiply over the exponent bits, built around one
// shared multiply-reduce unit under a small sequencer.
// ----------------------------------------------------------------------------
// One beat in gives one beat out: power_result = base_value ^ exponent_value
// mod modulus_value, exact for every bit pattern (the base is reduced first).
// A zero exponent answers 1 for any modulus, a zero modulus with a nonzero
// exponent answers 0; both pass straight to the finish state and the output
// register, then return to idle for the next beat. Otherwise every modular
// multiply goes through the shared unit, which registers the 16x16 product and
// then runs a two-bit restoring reduction. The base reduction is one job.
// Leading zero exponent bits are skipped in the scan state, and the highest
// set bit loads the accumulator directly; each lower bit issues a square from
// the scan state, and a set bit adds a multiply issued as the square lands.
// The finish state waits for the output to be free, then the block returns
// to idle. The block takes no new beat while an item is in flight, but the
// result sits in its own output register, so the next beat can be taken while
// it waits.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  mexp_pkg::mod_word_t     base_value,
  input  mexp_pkg::exp_word_t     exponent_value,
  input  mexp_pkg::mod_word_t     modulus_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mexp_pkg::mod_word_t     power_result
);
  import mexp_pkg::*;

  mexp_state_t state;
  mexp_state_t state_next;

  exp_word_t   expo;
  mod_word_t   modulus;
  mod_word_t   base_red;
  mod_word_t   acc;
  bit_idx_t    bit_idx;
  logic        started;

  mexp_req_t   req;
  mexp_rsp_t   rsp;

  logic        in_fire;
  logic        cur_bit;
  logic        last_bit;
  logic        out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign cur_bit  = expo[bit_idx];
  assign last_bit = (bit_idx == '0);
  assign out_free = !out_valid || out_ready;

  // Pick the operands for the shared unit: base reduction on a fresh beat,
  // square from the scan state, multiply right after a square lands.
  always_comb begin
    req.start   = 1'b0;
    req.op_a    = acc;
    req.op_b    = acc;
    req.modulus = modulus;
    unique case (state)
      ST_IDLE: begin
        req.op_a    = base_value;
        req.op_b    = MOD_BITS'(1);
        req.modulus = modulus_value;
        req.start   = in_fire && (exponent_value != '0) && (modulus_value != '0);
      end
      ST_SCAN: begin
        req.start = started;
      end
      ST_SQUARE: begin
        req.op_a  = rsp.result;
        req.op_b  = base_red;
        req.start = rsp.done && cur_bit;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  mexp_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if ((exponent_value == '0) || (modulus_value == '0)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (rsp.done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (started) begin
          state_next = ST_SQUARE;
        end else if (cur_bit && last_bit) begin
          state_next = ST_FINISH;
        end
      end
      ST_SQUARE: begin
        if (rsp.done) begin
          if (cur_bit) begin
            state_next = ST_MULT;
          end else if (last_bit) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_MULT: begin
        if (rsp.done) begin
          state_next = last_bit ? ST_FINISH : ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control: state, scan progress and the output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_REDUCE) begin
        started <= 1'b0;
      end else if ((state == ST_SCAN) && cur_bit) begin
        started <= 1'b1;
      end
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          expo    <= exponent_value;
          modulus <= modulus_value;
          // Special answers go straight to the finish state through acc
          acc     <= (exponent_value == '0) ? MOD_BITS'(1) : '0;
        end
      end
      ST_REDUCE: begin
        if (rsp.done) begin
          base_red <= rsp.result;
          bit_idx  <= IDX_W'(EXP_BITS - 1);
        end
      end
      ST_SCAN: begin
        // Leading zeros leave acc alone: skip them; the top set bit loads base
        if (!started) begin
          if (cur_bit) begin
            acc <= base_red;
          end
          if (!last_bit) begin
            bit_idx <= bit_idx - IDX_W'(1);
          end
        end
      end
      ST_SQUARE: begin
        if (rsp.done) begin
          acc <= rsp.result;
          if (!cur_bit && !last_bit) begin
            bit_idx <= bit_idx - IDX_W'(1);
          end
        end
      end
      ST_MULT: begin
        if (rsp.done) begin
          acc <= rsp.result;
          if (!last_bit) begin
            bit_idx <= bit_idx - IDX_W'(1);
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          power_result <= acc;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/mexp_modmul.sv =====
// ----------------------------------------------------------------------------
// mexp_modmul: shared multiply-reduce unit
// Registers a * b, then reduces the product by the modulus with a restoring
// remainder loop that retires two product bits per cycle.
// ----------------------------------------------------------------------------
module mexp_modmul (
  input  logic                clk,
  input  logic                rst,
  input  mexp_pkg::mexp_req_t req,
  output mexp_pkg::mexp_rsp_t rsp
);
  import mexp_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step_cnt;
  logic [PROD_W-1:0] prod;
  mod_word_t         modulus;
  mod_word_t         rem;
  mod_word_t         rem_next;
  logic              last_step;

  assign last_step = (step_cnt == STEP_W'(1));

  // Two dependent shift-compare-subtract steps; rem stays below modulus
  always_comb begin
    logic [MOD_BITS:0] r_hi;
    logic [MOD_BITS:0] r_lo;
    r_hi = {rem, prod[PROD_W-1]};
    if (r_hi >= {1'b0, modulus}) begin
      r_hi = r_hi - {1'b0, modulus};
    end
    r_lo = {r_hi[MOD_BITS-1:0], prod[PROD_W-2]};
    if (r_lo >= {1'b0, modulus}) begin
      r_lo = r_lo - {1'b0, modulus};
    end
    rem_next = r_lo[MOD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last_step;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last_step) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod     <= {{MOD_BITS{1'b0}}, req.op_a} * {{MOD_BITS{1'b0}}, req.op_b};
      modulus  <= req.modulus;
      rem      <= '0;
      step_cnt <= STEP_W'(RED_STEPS);
    end else if (busy) begin
      prod     <= prod << 2;
      rem      <= rem_next;
      step_cnt <= step_cnt - STEP_W'(1);
    end
  end

  assign rsp.done   = done;
  assign rsp.result = rem;

endmodule

// ===== rtl/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker: port-level checks for modular_exponentiation
// Watches the two channels and flags broken output holds, busy acceptance,
// output valid after reset and wrong answers on the zero-exponent fast path.
// ----------------------------------------------------------------------------
module mexp_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input mexp_pkg::exp_word_t exponent_value,
  input logic                out_valid,
  input logic                out_ready,
  input mexp_pkg::mod_word_t power_result
);
  import mexp_pkg::*;

  // A stalled output beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(power_result))
    else $error("output beat changed while stalled");

  // One item at a time: no second beat right after an accepted one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Reset drops the output beat
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Zero exponent answers 1 via the finish state and the output register when the output is free
  a_zero_exp: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (exponent_value == '0) && !out_valid
      |=> ##1 (out_valid && (power_result == MOD_BITS'(1))))
    else $error("zero exponent did not give 1");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .exponent_value (exponent_value),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .power_result   (power_result)
);

// ===== tb/tb_modular_exponentiation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation: self-checking bench for base ^ exponent mod modulus
// Drives operand beats through the valid/ready input, predicts every power
// with an independent square-and-multiply model and compares each output beat
// in order. Both sides idle at random; one phase holds the output off long
// enough to back the block up, and another runs with no idling at all.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam int LIMIT_CYCLES   = 4_000_000; // far above the slowest legal run
  localparam int HOLDOFF_CYCLES = 1500;      // long output stall, fills the block
  localparam int TAIL_CYCLES    = 60;        // quiet time after the last result
  localparam int IDLE_PERCENT   = 26;

  // Expected powers, one per accepted operand beat, in acceptance order.
  class power_scoreboard;
    mod_word_t expected_powers[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Left-to-right square-and-multiply with 64-bit intermediates.
    function mod_word_t reduced_power(mod_word_t b, exp_word_t e, mod_word_t m);
      longint unsigned acc;
      longint unsigned base_red;
      if (e == '0) return mod_word_t'(1);
      if (m == '0) return '0;
      base_red = b % m;
      acc      = 1;
      for (int i = EXP_BITS - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (e[i]) acc = (acc * base_red) % m;
      end
      return acc[MOD_BITS-1:0];
    endfunction

    function void note_operands(mod_word_t b, exp_word_t e, mod_word_t m);
      expected_powers.push_back(reduced_power(b, e, m));
    endfunction

    function void check_power(mod_word_t actual);
      mod_word_t want;
      if (expected_powers.size() == 0) begin
        $display("%0t ns: power_result beat with nothing pending, expected none, actual %0d",
                 $time, actual);
        errors++;
        return;
      end
      want = expected_powers.pop_front();
      if (actual !== want) begin
        $display("%0t ns: power_result mismatch, expected %0d, actual %0d",
                 $time, want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_powers.size();
    endfunction
  endclass

  logic      clk;
  logic      rst            = 1'b1;
  logic      in_valid       = 1'b0;
  logic      in_ready;
  mod_word_t base_value     = '0;
  exp_word_t exponent_value = '0;
  mod_word_t modulus_value  = '0;
  logic      out_valid;
  logic      out_ready      = 1'b0;
  mod_word_t power_result;

  // Phase controls, written with nonblocking assignments so every process
  // sees a change on the same edge.
  logic steady      = 1'b0; // no idling on either side
  logic holdoff_req = 1'b0; // ask the receiver for one long stall

  power_scoreboard sb;

  modular_exponentiation uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .base_value     (base_value),
    .exponent_value (exponent_value),
    .modulus_value  (modulus_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .power_result   (power_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Monitor both channels on the edge that completes the handshake. Retire
  // the output beat before noting a new input, so a beat taken on the same
  // edge lands behind the one leaving.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_power(power_result);
      if (in_valid && in_ready) sb.note_operands(base_value, exponent_value, modulus_value);
    end
  end

  // Receiver: random back-pressure, none in steady phases, and one long
  // hold-off counted here while the sender keeps offering beats.
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req <= 1'b0;
        out_ready   <= 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: drop the run if it outlasts LIMIT_CYCLES.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one operand beat, hold it until taken, then maybe idle a while.
  task automatic send_beat(mod_word_t b, exp_word_t e, mod_word_t m);
    in_valid       <= 1'b1;
    base_value     <= b;
    exponent_value <= e;
    modulus_value  <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Random operands; exponents up to max_bits wide keep most items short.
  task automatic send_random(int max_bits);
    int        width;
    int        sel;
    exp_word_t e;
    mod_word_t b;
    mod_word_t m;
    sel = $urandom_range(19);
    if (sel == 0)      m = '0;
    else if (sel == 1) m = mod_word_t'(1);
    else if (sel < 8)  m = mod_word_t'($urandom);
    else               m = mod_word_t'($urandom_range(2, 46340));

    sel = $urandom_range(9);
    if (sel < 3)       b = mod_word_t'($urandom);
    else if (sel == 3) b = m;
    else if (sel == 4) b = m - 1'b1;
    else               b = mod_word_t'($urandom_range(0, 46340));

    width = $urandom_range(1, max_bits);
    e = exp_word_t'($urandom) & exp_word_t'((64'd1 << width) - 1);
    if ($urandom_range(1)) e[width-1] = 1'b1;   // use the full width often
    if ($urandom_range(19) == 0) e = '0;
    send_beat(b, e, m);
  endtask

  // Stop offering and wait for every pending power. Sample at the falling
  // edge so the monitor's update on the rising edge is already in.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  initial begin
    int n;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Zero exponent answers one for any modulus, including one and zero.
    send_beat(16'd0,     31'd0,          16'd1);
    send_beat(16'd65535, 31'd0,          16'd0);
    send_beat(16'd46340, 31'd0,          16'd46340);
    send_beat(16'd0,     31'd0,          16'd65535);
    // Modulus of one and zero modulus with a nonzero exponent answer zero.
    send_beat(16'd12345, 31'd7,          16'd1);
    send_beat(16'd65535, 31'd1,          16'd1);
    send_beat(16'd12345, 31'd7,          16'd0);
    // Zero base.
    send_beat(16'd0,     31'd5,          16'd7);
    send_beat(16'd0,     31'h7fff_ffff,  16'd65535);
    // Base at or above the modulus gets reduced first.
    send_beat(16'd65535, 31'd3,          16'd46340);
    send_beat(16'd46340, 31'd9,          16'd46340);
    send_beat(16'd65535, 31'h7fff_ffff,  16'd65535);
    send_beat(16'd46340, 31'h7fff_ffff,  16'd46339);
    // Full-width exponents and single-bit exponents at both ends.
    send_beat(16'd46339, 31'h7fff_ffff,  16'd46340);
    send_beat(16'd65534, 31'h7fff_ffff,  16'd65535);
    send_beat(16'd3,     31'h4000_0000,  16'd65521);
    send_beat(16'd7,     31'd1,          16'd13);
    send_beat(16'd1,     31'h7fff_ffff,  16'd2);
    send_beat(16'd2,     31'd10,         16'd65535);
    send_beat(16'd65535, 31'd2,          16'd65521);

    // Sender pause: let every pending power come back.
    drain_results();

    // Long output stall while quick beats keep coming, so the block fills
    // and drops in_ready.
    holdoff_req <= 1'b1;
    for (n = 0; n < 12; n++) send_random(2);
    drain_results();

    // Stretch with no idling on either side.
    steady <= 1'b1;
    for (n = 0; n < 60; n++) send_random(($urandom_range(99) < 15) ? EXP_BITS : 12);
    steady <= 1'b0;

    for (n = 0; n < 450; n++) send_random(($urandom_range(99) < 15) ? EXP_BITS : 12);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
